// ===== design/asd_pkg.sv =====
// Shared types and constants for the accelerometer step detector.
// Used by every module of the block; depends on nothing else.
package asd_pkg;

	localparam int MAG_W     = 11;
	localparam int AVG_W     = 11;
	localparam int TOTAL_W   = 16;
	localparam int PHASE_W   = 2;
	localparam int SETTLE_W  = 4;
	localparam int ALPHA_W   = 10;
	localparam int OVS_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam int EWMA_SHIFT = 10;

	localparam int OUT_BITS    = MAG_W + AVG_W + TOTAL_W + PHASE_W + 1;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [ALPHA_W-1:0]  ALPHA_FULL     = 10'd1023;
	localparam logic [ALPHA_W-1:0]  ALPHA_RESET    = 10'd128;
	localparam logic [OVS_W-1:0]    OVS_RESET      = 8'd25;
	localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 4'd5;
	localparam logic [SETTLE_W-1:0] SETTLE_MAX     = 4'd15;
	localparam logic [MAG_W-1:0]    MAG_MAX        = 11'h7FF;
	localparam logic [MAG_W-1:0]    VALLEY_INIT    = 11'd1024;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERSHOOT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 2'd2;

	typedef enum logic [PHASE_W-1:0] {
		PH_SEEK_MAX  = 2'd0,
		PH_SEEK_FALL = 2'd1,
		PH_SEEK_MIN  = 2'd2,
		PH_SEEK_RISE = 2'd3
	} phase_t;

	// Command to the shared multiply-accumulate unit.
	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

	// Detector settings taken from the configuration registers.
	typedef struct packed {
		logic [OVS_W-1:0]    overshoot;
		logic [SETTLE_W-1:0] settle_target;
	} det_cfg_t;

	// What the detector reports for the item it has just processed.
	typedef struct packed {
		logic               step_seen;
		phase_t             phase;
		logic [TOTAL_W-1:0] step_count;
		logic [AVG_W-1:0]   average;
	} det_res_t;

endpackage

// ===== design/asd_mac.sv =====
// Shared multiply-accumulate unit of the step detector.
// Depends on asd_pkg for the command struct.
module asd_mac #(
	parameter int MUL_W = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  asd_pkg::mac_ctl_t    ctl,
	input  logic [MUL_W-1:0]     op_a,
	input  logic [MUL_W-1:0]     op_b,
	output logic [2*MUL_W+1:0]   acc
);
	import asd_pkg::*;

	localparam int ACC_W = 2 * MUL_W + 2;

	logic [ACC_W-1:0]   acc_q;
	logic [2*MUL_W-1:0] prod;

	assign prod = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= (ctl.clr ? '0 : acc_q) + ACC_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule

// ===== design/asd_isqrt.sv =====
// Bit-per-cycle floor integer square root for the step detector.
// Restoring digit recurrence; no package dependencies beyond asd_pkg import.
module asd_isqrt #(
	parameter int SUM_W  = 22,
	parameter int ROOT_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  value,
	output logic              busy,
	output logic [ROOT_W-1:0] root
);
	import asd_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [SUM_W-1:0]  val_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              take;

	// Bring down the next two bits and try to subtract 4*root+1.
	assign rem_sh = {rem_q[ROOT_W-1:0], val_q[SUM_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[SUM_W-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== design/asd_detector.sv =====
// Moving average and four-phase peak/valley step detector state.
// Depends on asd_pkg for phase codes, settings and result structs.
module asd_detector (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     update,
	input  logic [asd_pkg::MAG_W-1:0] mag,
	input  logic [asd_pkg::AVG_W-1:0] ewma,
	input  asd_pkg::det_cfg_t         cfg,
	output logic [asd_pkg::AVG_W-1:0] avg,
	output asd_pkg::det_res_t         res
);
	import asd_pkg::*;

	logic                seeded_q;
	logic [AVG_W-1:0]    avg_q;
	logic [MAG_W-1:0]    peak_q;
	logic [MAG_W-1:0]    valley_q;
	logic [SETTLE_W-1:0] settle_q;
	phase_t              phase_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [AVG_W-1:0]    avg_n;
	logic [MAG_W-1:0]    peak_n;
	logic [MAG_W-1:0]    valley_n;
	logic [SETTLE_W-1:0] settle_n;
	logic [SETTLE_W-1:0] settle_inc;
	phase_t              phase_n;
	logic [TOTAL_W-1:0]  total_n;
	logic                seen;
	logic                fell;
	logic                rose;

	assign settle_inc = (settle_q < SETTLE_MAX) ? settle_q + SETTLE_W'(1) : settle_q;

	// The fall threshold wraps below zero, which means it is always crossed.
	assign fell = (avg_n < AVG_W'(cfg.overshoot)) ||
	              (mag < avg_n - AVG_W'(cfg.overshoot));
	assign rose = {1'b0, mag} > ({1'b0, avg_n} + (AVG_W + 1)'(cfg.overshoot));

	always_comb begin
		avg_n    = seeded_q ? ewma : mag;
		peak_n   = peak_q;
		valley_n = valley_q;
		settle_n = settle_q;
		phase_n  = phase_q;
		seen     = 1'b0;
		if (seeded_q) begin
			case (phase_q)
				PH_SEEK_MAX: begin
					if (mag > peak_q) begin
						peak_n   = mag;
						settle_n = '0;
					end else begin
						settle_n = settle_inc;
						if (settle_inc >= cfg.settle_target) begin
							phase_n = PH_SEEK_FALL;
						end
					end
				end
				PH_SEEK_FALL: begin
					if (mag > peak_q) begin
						peak_n   = mag;
						settle_n = '0;
						phase_n  = PH_SEEK_MAX;
					end else if (fell) begin
						seen     = 1'b1;
						valley_n = VALLEY_INIT;
						settle_n = '0;
						phase_n  = PH_SEEK_MIN;
					end
				end
				PH_SEEK_MIN: begin
					if (mag < valley_q) begin
						valley_n = mag;
						settle_n = '0;
					end else begin
						settle_n = settle_inc;
						if (settle_inc >= cfg.settle_target) begin
							phase_n = PH_SEEK_RISE;
						end
					end
				end
				PH_SEEK_RISE: begin
					if (mag < valley_q) begin
						valley_n = mag;
						settle_n = '0;
						phase_n  = PH_SEEK_MIN;
					end else if (rose) begin
						seen     = 1'b1;
						peak_n   = '0;
						settle_n = '0;
						phase_n  = PH_SEEK_MAX;
					end
				end
				default: begin
					phase_n = PH_SEEK_MAX;
				end
			endcase
		end
		total_n = total_q + TOTAL_W'(seen);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			avg_q    <= '0;
			peak_q   <= '0;
			valley_q <= VALLEY_INIT;
			settle_q <= '0;
			phase_q  <= PH_SEEK_MAX;
			total_q  <= '0;
		end else if (update) begin
			seeded_q <= 1'b1;
			avg_q    <= avg_n;
			peak_q   <= peak_n;
			valley_q <= valley_n;
			settle_q <= settle_n;
			phase_q  <= phase_n;
			total_q  <= total_n;
		end
	end

	assign avg            = avg_q;
	assign res.average    = avg_n;
	assign res.step_count = total_n;
	assign res.phase      = phase_n;
	assign res.step_seen  = seen;

endmodule

// ===== design/accel_step_detector_top.sv =====
// Top level of the accelerometer step detector: sequencer, configuration
// registers and output register. Depends on asd_pkg, asd_mac, asd_isqrt, asd_detector.
//
// Usage. Each input word on s_* carries one three-axis sample. For every
// accepted word the block returns exactly one output word on m_* with the
// sample's magnitude (floor square root of the sum of squares), the moving
// average after this sample, the running step total, the detector phase and
// a flag set when this sample completed a step. The first sample after reset
// only seeds the average and never counts a step.
//
// Flow. s_tready rises again at the same edge at which a sample's output
// word becomes valid; the block takes no new sample before it is through
// with the last. The three squares and the two average products go one per
// cycle through a single shared multiplier; the square root is the
// bit-per-cycle unit. The block works on one sample at a time.
//
// Reset puts the average, detector and step total in their initial state and
// loads the default settings. If the receiver stalls, a finished result waits
// in the output register and the next sample is still accepted and processed;
// the block only holds at its final step until the output register is free.
// Configuration writes are meant to happen while no sample is in flight.
module accel_step_detector_top #(
	parameter int ACCEL_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,

	// Fields from bit 0 up: accel_x, accel_y, accel_z, zero padding.
	input  logic [((3*ACCEL_BITS+7)/8)*8-1:0] s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,

	// Fields from bit 0 up: magnitude, average, step_count,
	// detector_phase, step_seen, zero padding.
	output logic [asd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,

	input  logic                              cfg_wr_en,
	input  logic [asd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [asd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import asd_pkg::*;

	localparam int MUL_W  = (ACCEL_BITS > MAG_W) ? ACCEL_BITS : MAG_W;
	localparam int ACC_W  = 2 * MUL_W + 2;
	localparam int SUM_W  = 2 * ACCEL_BITS + 2;
	localparam int ROOT_W = ACCEL_BITS + 1;
	localparam int EXT_W  = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SQUARE  = 6'b000010,
		ST_ROOT_GO = 6'b000100,
		ST_ROOT    = 6'b001000,
		ST_AVG     = 6'b010000,
		ST_DETECT  = 6'b100000
	} seq_state_t;

	seq_state_t state_q;
	logic [1:0] step_q;

	logic [ACCEL_BITS-1:0] ax_q;
	logic [ACCEL_BITS-1:0] ay_q;
	logic [ACCEL_BITS-1:0] az_q;

	logic [ALPHA_W-1:0]  alpha_q;
	logic [OVS_W-1:0]    overshoot_q;
	logic [SETTLE_W-1:0] settle_target_q;

	logic [OUT_TDATA_W-1:0] out_q;
	logic                   out_valid_q;

	mac_ctl_t          mac_ctl;
	logic [MUL_W-1:0]  op_a;
	logic [MUL_W-1:0]  op_b;
	logic [ACC_W-1:0]  acc;
	logic [ACCEL_BITS-1:0] axis_sel;

	logic              root_start;
	logic              root_busy;
	logic [ROOT_W-1:0] root;
	logic [EXT_W-1:0]  root_ext;
	logic [MAG_W-1:0]  mag;
	logic [AVG_W-1:0]  ewma;
	logic [AVG_W-1:0]  avg;

	det_cfg_t det_cfg;
	det_res_t det_res;
	logic     out_free;
	logic     det_update;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q         <= ALPHA_RESET;
			overshoot_q     <= OVS_RESET;
			settle_target_q <= SETTLE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ALPHA:     alpha_q         <= cfg_data[ALPHA_W-1:0];
				REG_OVERSHOOT: overshoot_q     <= cfg_data[OVS_W-1:0];
				REG_SETTLE:    settle_target_q <= cfg_data[SETTLE_W-1:0];
				default:       ;
			endcase
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || m_tready;
	assign det_update = (state_q == ST_DETECT) && out_free;
	assign root_start = (state_q == ST_ROOT_GO);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (s_tvalid) begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (step_q == 2'd2) begin
						step_q  <= '0;
						state_q <= ST_ROOT_GO;
					end else begin
						step_q <= step_q + 2'd1;
					end
				end
				ST_ROOT_GO: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (!root_busy) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (step_q == 2'd1) begin
						step_q  <= '0;
						state_q <= ST_DETECT;
					end else begin
						step_q <= step_q + 2'd1;
					end
				end
				ST_DETECT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample capture at acceptance.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ax_q <= s_tdata[ACCEL_BITS-1:0];
			ay_q <= s_tdata[2*ACCEL_BITS-1:ACCEL_BITS];
			az_q <= s_tdata[3*ACCEL_BITS-1:2*ACCEL_BITS];
		end
	end

	// Operand selection for the shared multiplier: three squares while summing,
	// then alpha*magnitude and (1023-alpha)*average for the moving average.
	always_comb begin
		case (step_q)
			2'd0:    axis_sel = ax_q;
			2'd1:    axis_sel = ay_q;
			default: axis_sel = az_q;
		endcase
		mac_ctl.en  = 1'b0;
		mac_ctl.clr = 1'b0;
		op_a        = MUL_W'(axis_sel);
		op_b        = MUL_W'(axis_sel);
		if (state_q == ST_SQUARE) begin
			mac_ctl.en  = 1'b1;
			mac_ctl.clr = (step_q == 2'd0);
		end else if (state_q == ST_AVG) begin
			mac_ctl.en = 1'b1;
			if (step_q == 2'd0) begin
				mac_ctl.clr = 1'b1;
				op_a        = MUL_W'(alpha_q);
				op_b        = MUL_W'(mag);
			end else begin
				op_a = MUL_W'(ALPHA_FULL - alpha_q);
				op_b = MUL_W'(avg);
			end
		end
	end

	asd_mac #(
		.MUL_W(MUL_W)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.op_a  (op_a),
		.op_b  (op_b),
		.acc   (acc)
	);

	asd_isqrt #(
		.SUM_W (SUM_W),
		.ROOT_W(ROOT_W)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (root_start),
		.value (acc[SUM_W-1:0]),
		.busy  (root_busy),
		.root  (root)
	);

	// Wide sample widths can give a root beyond the field; it saturates.
	assign root_ext = EXT_W'(root);
	assign mag      = (root_ext > EXT_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];
	assign ewma     = acc[EWMA_SHIFT+AVG_W-1:EWMA_SHIFT];

	assign det_cfg.overshoot     = overshoot_q;
	assign det_cfg.settle_target = settle_target_q;

	asd_detector u_detector (
		.clk   (clk),
		.arst_n(arst_n),
		.update(det_update),
		.mag   (mag),
		.ewma  (ewma),
		.cfg   (det_cfg),
		.avg   (avg),
		.res   (det_res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (det_update) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (det_update) begin
			out_q <= OUT_TDATA_W'({det_res.step_seen, det_res.phase,
			                       det_res.step_count, det_res.average, mag});
		end
	end

	assign m_tdata  = out_q;
	assign m_tvalid = out_valid_q;

endmodule
